[sv/rmsn_pkg.sv]
// ----------------------------------------------------------------------------
// rmsn_pkg: shared types and constants for the two-pass RMS normalization core
// Operation codes, register indexes, reset values and the request and
// response records exchanged between the sequencer and the floating-point unit.
// ----------------------------------------------------------------------------
package rmsn_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_WEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BF16  = 2'd3;

  localparam logic [15:0] RST_ROW_LENGTH   = 16'd1;
  localparam logic [31:0] RST_EPSILON_BITS = 32'h358637BD;
  localparam logic        RST_USE_WEIGHT   = 1'b1;
  localparam logic        RST_OUTPUT_BF16  = 1'b0;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;
  localparam logic [1:0] OP_RSQ = 2'd3;

  localparam logic [31:0] NAN_DEFAULT = 32'hFFC00000;
  localparam logic [31:0] NAN_POS     = 32'h7FC00000;
  localparam logic [31:0] QUIET_BIT   = 32'h00400000;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] divisor;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

endpackage

[sv/rmsn_cfg_if.sv]
// ----------------------------------------------------------------------------
// rmsn_cfg_if: register write channel
// Carries a register index and write data under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmsn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rmsn_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[sv/rmsn_in_if.sv]
// ----------------------------------------------------------------------------
// rmsn_in_if: element input channel
// Carries the command, the bf16 element and the bf16 weight.
// ----------------------------------------------------------------------------
interface rmsn_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] x_bits;
  logic [15:0] weight_bits;

  modport source(output valid, output command, output x_bits, output weight_bits,
                 input ready);
  modport sink(input valid, input command, input x_bits, input weight_bits,
               output ready);
endinterface

[sv/rmsn_out_if.sv]
// ----------------------------------------------------------------------------
// rmsn_out_if: result output channel
// Carries the result value bits and the flag that marks a row rstd.
// ----------------------------------------------------------------------------
interface rmsn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic        is_rstd;

  modport source(output valid, output value_bits, output is_rstd, input ready);
  modport sink(input valid, input value_bits, input is_rstd, output ready);
endinterface

[sv/rmsn_fpu.sv]
// ----------------------------------------------------------------------------
// rmsn_fpu: iterative single-precision arithmetic unit
// Multiply, add, divide by an integer and reciprocal square root, all
// correctly rounded, built around one normalize-and-round stage, a bit-serial
// divider and a bit-serial root search.
// ----------------------------------------------------------------------------
module rmsn_fpu (
  input  logic                clk,
  input  logic                rst,
  input  rmsn_pkg::fpu_req_t  req,
  output rmsn_pkg::fpu_rsp_t  rsp
);

  localparam logic [2:0] F_IDLE    = 3'd0;
  localparam logic [2:0] F_NORM    = 3'd1;
  localparam logic [2:0] F_DIV     = 3'd2;
  localparam logic [2:0] F_PACK    = 3'd3;
  localparam logic [2:0] F_RSQ     = 3'd4;
  localparam logic [2:0] F_RSQ_RND = 3'd5;

  localparam logic [78:0] RSQ_ONE  = 79'd1 << 74;
  localparam logic [74:0] RSQ_ONE75 = 75'd1 << 74;

  logic [2:0]         state;
  logic [1:0]         op;
  logic               sign;
  logic signed [11:0] e;
  logic [49:0]        m;
  logic [15:0]        rem;
  logic [5:0]         cnt;
  logic [74:0]        p;
  logic [50:0]        racc;
  logic [25:0]        r;
  logic [15:0]        divisor;
  logic               done;
  logic [31:0]        result;

  // Operand decode.
  logic [7:0]  a_exp, b_exp, a_e8, b_e8;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] a_mant, b_mant;
  logic signed [11:0] a_e, b_e;
  logic [47:0] prod;

  assign a_exp  = req.a[30:23];
  assign b_exp  = req.b[30:23];
  assign a_nan  = (a_exp == 8'hFF) && (req.a[22:0] != 23'd0);
  assign b_nan  = (b_exp == 8'hFF) && (req.b[22:0] != 23'd0);
  assign a_inf  = (a_exp == 8'hFF) && (req.a[22:0] == 23'd0);
  assign b_inf  = (b_exp == 8'hFF) && (req.b[22:0] == 23'd0);
  assign a_zero = (req.a[30:0] == 31'd0);
  assign b_zero = (req.b[30:0] == 31'd0);
  assign a_mant = {a_exp != 8'd0, req.a[22:0]};
  assign b_mant = {b_exp != 8'd0, req.b[22:0]};
  assign a_e8   = (a_exp == 8'd0) ? 8'd1 : a_exp;
  assign b_e8   = (b_exp == 8'd0) ? 8'd1 : b_exp;
  assign a_e    = signed'({4'd0, a_e8});
  assign b_e    = signed'({4'd0, b_e8});
  assign prod   = a_mant * b_mant;

  // Alignment and add for the add operation.
  logic        swap;
  logic [23:0] big_mant, small_mant;
  logic [7:0]  big_e8, small_e8, al_d;
  logic [5:0]  al_dd;
  logic [49:0] al_x, al_y, al_ysh, al_mask, al_yj, al_sum;
  logic        al_lost, big_sign;

  assign swap       = req.b[30:0] > req.a[30:0];
  assign big_mant   = swap ? b_mant : a_mant;
  assign small_mant = swap ? a_mant : b_mant;
  assign big_e8     = swap ? b_e8 : a_e8;
  assign small_e8   = swap ? a_e8 : b_e8;
  assign big_sign   = swap ? req.b[31] : req.a[31];
  assign al_d       = big_e8 - small_e8;
  assign al_dd      = (al_d > 8'd50) ? 6'd50 : al_d[5:0];
  assign al_x       = {1'b0, big_mant, 25'd0};
  assign al_y       = {1'b0, small_mant, 25'd0};
  assign al_ysh     = al_y >> al_dd;
  assign al_mask    = (50'd1 << al_dd) - 50'd1;
  assign al_lost    = |(al_y & al_mask);
  assign al_yj      = al_ysh | {49'd0, al_lost};
  assign al_sum     = (req.a[31] == req.b[31]) ? (al_x + al_yj) : (al_x - al_yj);

  // Final normalize-and-round stage.
  logic signed [11:0] pk_biased, pk_dsub;
  logic               pk_ovf, pk_sub, pk_lost, pk_up;
  logic [5:0]         pk_dd;
  logic [49:0]        pk_sh, pk_mask;
  logic [23:0]        pk_keep;
  logic [7:0]         pk_expf;
  logic [30:0]        pk_body;

  assign pk_biased = e + 12'sd176;
  assign pk_ovf    = pk_biased > 12'sd254;
  assign pk_sub    = pk_biased < 12'sd1;
  assign pk_dsub   = 12'sd1 - pk_biased;
  assign pk_dd     = !pk_sub ? 6'd0 : ((pk_dsub > 12'sd50) ? 6'd50 : pk_dsub[5:0]);
  assign pk_sh     = m >> pk_dd;
  assign pk_mask   = (50'd1 << pk_dd) - 50'd1;
  assign pk_lost   = |(m & pk_mask);
  assign pk_keep   = pk_sh[49:26];
  assign pk_up     = pk_sh[25] & ((|pk_sh[24:0]) | pk_lost | pk_keep[0]);
  assign pk_expf   = pk_sub ? 8'd0 : pk_biased[7:0];
  assign pk_body   = {pk_expf, pk_keep[22:0]} + {30'd0, pk_up};

  // Divider step.
  logic [16:0] dv_sh;
  logic        dv_ge;
  logic [15:0] dv_rem;

  assign dv_sh  = {rem, m[49]};
  assign dv_ge  = dv_sh >= {1'b0, divisor};
  assign dv_rem = dv_ge ? 16'(dv_sh - {1'b0, divisor}) : dv_sh[15:0];

  // Root search step: tests (r + 2^cnt)^2 * m against 2^74.
  logic [78:0] rs_sum;
  logic        rs_take;

  assign rs_sum  = 79'(p) + (79'(racc) << (cnt + 6'd1)) + (79'(m[24:0]) << {cnt, 1'b0});
  assign rs_take = rs_sum <= RSQ_ONE;

  // Root rounding.
  logic               rr_sticky, rr_up;
  logic [23:0]        rr_keep;
  logic signed [11:0] rr_half, rr_field;

  assign rr_sticky = p != RSQ_ONE75;
  assign rr_keep   = r[25] ? r[25:2] : r[24:1];
  assign rr_up     = r[25] ? (r[1] & (r[0] | rr_sticky | r[2])) : (r[0] & (rr_sticky | r[1]));
  assign rr_half   = e >>> 1;
  assign rr_field  = 12'sd113 - rr_half + (r[25] ? 12'sd2 : 12'sd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (req.start) begin
            op      <= req.op;
            divisor <= req.divisor;
            unique case (req.op)
              rmsn_pkg::OP_MUL: begin
                priority if (a_nan) begin
                  result <= req.a | rmsn_pkg::QUIET_BIT; done <= 1'b1;
                end else if (b_nan) begin
                  result <= req.b | rmsn_pkg::QUIET_BIT; done <= 1'b1;
                end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                  result <= rmsn_pkg::NAN_DEFAULT; done <= 1'b1;
                end else if (a_inf || b_inf) begin
                  result <= {req.a[31] ^ req.b[31], 8'hFF, 23'd0}; done <= 1'b1;
                end else if (a_zero || b_zero) begin
                  result <= {req.a[31] ^ req.b[31], 31'd0}; done <= 1'b1;
                end else begin
                  m     <= {2'd0, prod};
                  e     <= a_e + b_e - 12'sd300;
                  sign  <= req.a[31] ^ req.b[31];
                  state <= F_PACK;
                end
              end
              rmsn_pkg::OP_ADD: begin
                priority if (a_nan) begin
                  result <= req.a | rmsn_pkg::QUIET_BIT; done <= 1'b1;
                end else if (b_nan) begin
                  result <= req.b | rmsn_pkg::QUIET_BIT; done <= 1'b1;
                end else if (a_inf && b_inf && (req.a[31] != req.b[31])) begin
                  result <= rmsn_pkg::NAN_DEFAULT; done <= 1'b1;
                end else if (a_inf) begin
                  result <= req.a; done <= 1'b1;
                end else if (b_inf) begin
                  result <= req.b; done <= 1'b1;
                end else if (a_zero && b_zero) begin
                  result <= {req.a[31] & req.b[31], 31'd0}; done <= 1'b1;
                end else if (a_zero) begin
                  result <= req.b; done <= 1'b1;
                end else if (b_zero) begin
                  result <= req.a; done <= 1'b1;
                end else if ((req.a[30:0] == req.b[30:0]) && (req.a[31] != req.b[31])) begin
                  result <= 32'd0; done <= 1'b1;
                end else begin
                  m     <= al_sum;
                  e     <= signed'({4'd0, big_e8}) - 12'sd175;
                  sign  <= big_sign;
                  state <= F_PACK;
                end
              end
              rmsn_pkg::OP_DIV: begin
                priority if (a_nan) begin
                  result <= req.a | rmsn_pkg::QUIET_BIT; done <= 1'b1;
                end else if (a_inf || a_zero) begin
                  result <= req.a; done <= 1'b1;
                end else begin
                  m     <= {26'd0, a_mant};
                  e     <= a_e - 12'sd150;
                  sign  <= req.a[31];
                  state <= F_NORM;
                end
              end
              rmsn_pkg::OP_RSQ: begin
                priority if (a_exp == 8'hFF) begin
                  result <= (req.a[22:0] != 23'd0 || req.a[31]) ? rmsn_pkg::NAN_POS : 32'd0;
                  done   <= 1'b1;
                end else if (a_zero) begin
                  result <= req.a[31] ? 32'hFF800000 : 32'h7F800000; done <= 1'b1;
                end else if (req.a[31]) begin
                  result <= rmsn_pkg::NAN_POS; done <= 1'b1;
                end else begin
                  m     <= {26'd0, a_mant};
                  e     <= a_e - 12'sd150;
                  sign  <= 1'b0;
                  state <= F_NORM;
                end
              end
              default: state <= F_IDLE;
            endcase
          end
        end
        F_NORM: begin
          if (!m[23]) begin
            m <= m << 1;
            e <= e - 12'sd1;
          end else if (op == rmsn_pkg::OP_DIV) begin
            m     <= {m[23:0], 26'd0};
            e     <= e - 12'sd26;
            rem   <= 16'd0;
            cnt   <= 6'd49;
            state <= F_DIV;
          end else begin
            if (e[0]) begin
              m <= m << 1;
              e <= e - 12'sd1;
            end
            p     <= 75'd0;
            racc  <= 51'd0;
            r     <= 26'd0;
            cnt   <= 6'd25;
            state <= F_RSQ;
          end
        end
        F_DIV: begin
          rem <= dv_rem;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            m     <= {m[48:0], dv_ge | (dv_rem != 16'd0)};
            state <= F_PACK;
          end else begin
            m <= {m[48:0], dv_ge};
          end
        end
        F_PACK: begin
          if (!m[49]) begin
            m <= m << 1;
            e <= e - 12'sd1;
          end else begin
            result <= pk_ovf ? {sign, 8'hFF, 23'd0} : {sign, pk_body};
            done   <= 1'b1;
            state  <= F_IDLE;
          end
        end
        F_RSQ: begin
          if (rs_take) begin
            p          <= rs_sum[74:0];
            racc       <= racc + (51'(m[24:0]) << cnt);
            r[cnt[4:0]] <= 1'b1;
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= F_RSQ_RND;
          end
        end
        F_RSQ_RND: begin
          result <= {1'b0, rr_field[7:0], rr_keep[22:0]} + {31'd0, rr_up};
          done   <= 1'b1;
          state  <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == F_IDLE))
    else $error("operation started while the unit is busy");

  a_pack_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == F_PACK) |-> (m != 50'd0))
    else $error("normalization entered with a zero mantissa");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (state == F_RSQ) |-> (p <= RSQ_ONE75))
    else $error("root search product exceeds its bound");
`endif

endmodule

[sv/rms_norm_two_pass_core.sv]
// ----------------------------------------------------------------------------
// rms_norm_two_pass_core: RMS normalization of bf16 rows in two passes
// Accumulates squares of a row, closes the row with a reciprocal RMS, and
// scales elements by it, optionally weighted, with f32 or bf16 output.
// ----------------------------------------------------------------------------
//  Channel  Role    Payload
//  cfg      sink    index, data            register writes, always ready
//  item     sink    command, x_bits, weight_bits
//  result   source  value_bits, is_rstd
//
//  One item at a time; all arithmetic runs through one shared iterative unit.
//  An accumulate squares the element and adds it to the sum; one that
//  closes a row then divides the sum by the row length, adds epsilon and
//  runs the root search; apply multiplies by the stored rstd and, if
//  weighted, by the weight. Subnormal operands are shifted to normalize them.
//  Reset restores all registers and clears the sum, count and stored rstd.
//  A held result does not stall input; the next result waits for it to drain.
// ----------------------------------------------------------------------------
module rms_norm_two_pass_core (
  input logic         clk,
  input logic         rst,
  rmsn_cfg_if.sink    cfg,
  rmsn_in_if.sink     item,
  rmsn_out_if.source  result
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ACC_SQ  = 4'd1;
  localparam logic [3:0] S_ACC_SUM = 4'd2;
  localparam logic [3:0] S_DIV     = 4'd3;
  localparam logic [3:0] S_EPS     = 4'd4;
  localparam logic [3:0] S_RSQ     = 4'd5;
  localparam logic [3:0] S_APP_X   = 4'd6;
  localparam logic [3:0] S_APP_W   = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  logic [3:0]         state;
  rmsn_pkg::fpu_req_t fpu_req;
  rmsn_pkg::fpu_rsp_t fpu_rsp;

  logic [15:0] row_length;
  logic [31:0] epsilon_bits;
  logic        use_weight;
  logic        output_bf16;
  logic [31:0] square_sum;
  logic [15:0] element_count;
  logic [31:0] inverse_rms;
  logic [15:0] weight;
  logic [31:0] res_value;
  logic        res_rstd;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_rstd;

  logic [15:0] len_eff;
  logic [15:0] count_next;

  function automatic logic [15:0] to_bf16(input logic [31:0] b);
    logic [31:0] s;
    s = b + 32'h00007FFF + {31'd0, b[16]};
    if ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) begin
      return b[31:16] | 16'h0040;
    end
    return s[31:16];
  endfunction

  assign len_eff    = (row_length == 16'd0) ? 16'd1 : row_length;
  assign count_next = element_count + 16'd1;

  rmsn_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fpu_req.start <= 1'b0;
      row_length    <= rmsn_pkg::RST_ROW_LENGTH;
      epsilon_bits  <= rmsn_pkg::RST_EPSILON_BITS;
      use_weight    <= rmsn_pkg::RST_USE_WEIGHT;
      output_bf16   <= rmsn_pkg::RST_OUTPUT_BF16;
      square_sum    <= 32'd0;
      element_count <= 16'd0;
      inverse_rms   <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      fpu_req.start <= 1'b0;

      if (cfg.valid) begin
        unique case (cfg.index)
          rmsn_pkg::CFG_ROW_LENGTH:   row_length   <= cfg.data[15:0];
          rmsn_pkg::CFG_EPSILON_BITS: epsilon_bits <= cfg.data;
          rmsn_pkg::CFG_USE_WEIGHT:   use_weight   <= cfg.data[0];
          rmsn_pkg::CFG_OUTPUT_BF16:  output_bf16  <= cfg.data[0];
          default: ;
        endcase
      end

      if (out_valid && result.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            weight          <= item.weight_bits;
            fpu_req.start   <= 1'b1;
            fpu_req.a       <= {item.x_bits, 16'd0};
            fpu_req.divisor <= len_eff;
            if (item.command) begin
              fpu_req.op <= rmsn_pkg::OP_MUL;
              fpu_req.b  <= inverse_rms;
              state      <= S_APP_X;
            end else begin
              fpu_req.op <= rmsn_pkg::OP_MUL;
              fpu_req.b  <= {item.x_bits, 16'd0};
              state      <= S_ACC_SQ;
            end
          end
        end
        S_ACC_SQ: begin
          if (fpu_rsp.done) begin
            fpu_req.start <= 1'b1;
            fpu_req.op    <= rmsn_pkg::OP_ADD;
            fpu_req.a     <= square_sum;
            fpu_req.b     <= fpu_rsp.result;
            state         <= S_ACC_SUM;
          end
        end
        S_ACC_SUM: begin
          if (fpu_rsp.done) begin
            square_sum <= fpu_rsp.result;
            if (count_next < len_eff) begin
              element_count <= count_next;
              state         <= S_IDLE;
            end else begin
              fpu_req.start <= 1'b1;
              fpu_req.op    <= rmsn_pkg::OP_DIV;
              fpu_req.a     <= fpu_rsp.result;
              state         <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (fpu_rsp.done) begin
            fpu_req.start <= 1'b1;
            fpu_req.op    <= rmsn_pkg::OP_ADD;
            fpu_req.a     <= fpu_rsp.result;
            fpu_req.b     <= epsilon_bits;
            state         <= S_EPS;
          end
        end
        S_EPS: begin
          if (fpu_rsp.done) begin
            fpu_req.start <= 1'b1;
            fpu_req.op    <= rmsn_pkg::OP_RSQ;
            fpu_req.a     <= fpu_rsp.result;
            state         <= S_RSQ;
          end
        end
        S_RSQ: begin
          if (fpu_rsp.done) begin
            inverse_rms   <= fpu_rsp.result;
            square_sum    <= 32'd0;
            element_count <= 16'd0;
            res_value     <= fpu_rsp.result;
            res_rstd      <= 1'b1;
            state         <= S_EMIT;
          end
        end
        S_APP_X: begin
          if (fpu_rsp.done) begin
            if (use_weight) begin
              fpu_req.start <= 1'b1;
              fpu_req.op    <= rmsn_pkg::OP_MUL;
              fpu_req.a     <= fpu_rsp.result;
              fpu_req.b     <= {weight, 16'd0};
              state         <= S_APP_W;
            end else begin
              res_value <= output_bf16 ? {16'd0, to_bf16(fpu_rsp.result)} : fpu_rsp.result;
              res_rstd  <= 1'b0;
              state     <= S_EMIT;
            end
          end
        end
        S_APP_W: begin
          if (fpu_rsp.done) begin
            res_value <= output_bf16 ? {16'd0, to_bf16(fpu_rsp.result)} : fpu_rsp.result;
            res_rstd  <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_value <= res_value;
            out_rstd  <= res_rstd;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cfg.ready         = 1'b1;
  assign item.ready        = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.value_bits = out_value;
  assign result.is_rstd    = out_rstd;

`ifndef NO_ASSERTIONS
  a_issue_on_accept: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> fpu_req.start)
    else $error("accepted transaction did not start the arithmetic unit");

  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    fpu_rsp.done |-> (state != S_IDLE && state != S_EMIT))
    else $error("arithmetic unit finished with no operation pending");

  a_rstd_stored: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && res_rstd) |-> (res_value == inverse_rms))
    else $error("emitted rstd differs from the stored value");
`endif

endmodule
